FILE: hw/rtl/sard_pkg.sv
package sard_pkg;

  // Fixed field widths.
  localparam int SLOT_W     = 10;
  localparam int TIME_W     = 32;
  localparam int RES_W      = 11;
  localparam int MS_W       = 16;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // A table entry holds the free flag above the free time.
  localparam int WORD_W = TIME_W + 1;

  localparam int SLOTS_DEF = 1024;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP   = 2'd2;

  // Register reset values.
  localparam logic [RES_W-1:0] RESERVED_RST = 11'd1;
  localparam logic [MS_W-1:0]  DELAY_RST    = 16'd500;
  localparam logic [MS_W-1:0]  WARMUP_RST   = 16'd2000;

  // Request functions.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BEYOND = 2'd2;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

FILE: hw/rtl/sard_req_if.sv
interface sard_req_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [sard_pkg::SLOT_W-1:0]  slot;
  logic [sard_pkg::TIME_W-1:0]  now_ms;

  modport source (output valid, func, slot, now_ms, input ready);
  modport sink (input valid, func, slot, now_ms, output ready);
endinterface

FILE: hw/rtl/sard_rsp_if.sv
interface sard_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [sard_pkg::SLOT_W-1:0]    slot_out;
  logic [sard_pkg::STATUS_W-1:0]  status;
  logic                           fresh;

  modport source (output valid, slot_out, status, fresh, input ready);
  modport sink (input valid, slot_out, status, fresh, output ready);
endinterface

FILE: hw/rtl/slot_allocator_reuse_delay_top.sv
// Slot allocator with a reuse delay.
// The req channel carries one request per transfer: func selects allocate or
// free, slot names the slot to free, now_ms is the current time. The rsp
// channel returns exactly one result per request: slot_out, status and fresh.
// The user must write the configuration registers, through cfg_we, cfg_index
// and cfg_data, only while no request is in flight; the block does not check.
// A free goes straight to the finishing state, skipping the scan. An allocate
// scans the table one entry per cycle through a single read port of the slot
// memory, from reserved_slots up to the high-water count, and stops at the
// first reusable slot; with none, it takes the slot at the count and raises
// the count, or reports full at SLOTS. One request is handled at a time;
// req.ready is high only while the block is idle, which it is again in the
// cycle after the result moves into the output register.
// After reset the block clears the slot memory, one entry per cycle, and
// accepts no request until that pass is over.
// The result sits in an output register until rsp.ready takes it; a stalled
// receiver holds the block in its finishing state, so no new request is
// accepted until the previous result has moved into that register.
module slot_allocator_reuse_delay_top #(
  parameter int SLOTS = sard_pkg::SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [sard_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sard_pkg::CFG_DATA_W-1:0]   cfg_data,
  sard_req_if.sink                          req,
  sard_rsp_if.source                        rsp
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int SW = (CW > sard_pkg::RES_W) ? CW : sard_pkg::RES_W;
  localparam logic [SW-1:0] SLOTS_W = SW'(SLOTS);
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
  localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);

  sard_pkg::state_t state, state_next;

  logic [sard_pkg::RES_W-1:0]    reserved_slots;
  logic [sard_pkg::MS_W-1:0]     reuse_delay_ms;
  logic [sard_pkg::MS_W-1:0]     warmup_ms;

  logic [IW-1:0]                 clr, clr_next;
  logic [CW-1:0]                 used_count, used_count_next;
  logic [sard_pkg::TIME_W-1:0]   req_now, req_now_next;
  logic [SW-1:0]                 idx, idx_next;
  logic [IW-1:0]                 chk, chk_next;
  logic                          pend, pend_next;
  logic [sard_pkg::SLOT_W-1:0]   res_slot, res_slot_next;
  logic [sard_pkg::STATUS_W-1:0] res_status, res_status_next;
  logic                          res_fresh, res_fresh_next;

  logic                          out_valid;
  logic [sard_pkg::SLOT_W-1:0]   out_slot;
  logic [sard_pkg::STATUS_W-1:0] out_status;
  logic                          out_fresh;
  logic                          load_out;
  logic                          in_ready;

  logic                          ram_we;
  logic [IW-1:0]                 ram_waddr;
  logic [sard_pkg::WORD_W-1:0]   ram_wdata;
  logic [IW-1:0]                 ram_raddr;
  logic [sard_pkg::WORD_W-1:0]   ram_rdata;

  logic                          r_flag;
  logic [sard_pkg::TIME_W-1:0]   r_time;
  logic [sard_pkg::TIME_W-1:0]   age;
  logic                          hit;
  logic                          issue;
  logic [SW-1:0]                 slot_w;
  logic [SW-1:0]                 floor_w;
  logic [SW-1:0]                 raised;

  sard_ram #(
    .WIDTH (sard_pkg::WORD_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Reuse test on the entry read in the previous cycle.
  assign r_flag = ram_rdata[sard_pkg::WORD_W-1];
  assign r_time = ram_rdata[sard_pkg::TIME_W-1:0];
  assign age    = req_now - r_time;
  assign hit    = r_flag &&
                  ((r_time < {16'd0, warmup_ms}) ||
                   ((req_now >= r_time) && (age > {16'd0, reuse_delay_ms})));

  assign issue   = idx < SW'(used_count);
  assign slot_w  = SW'(req.slot);
  assign floor_w = (SW'(reserved_slots) < SLOTS_W) ? SW'(reserved_slots) : SLOTS_W;
  assign raised  = (SW'(used_count) < floor_w) ? floor_w : SW'(used_count);

  always_comb begin
    state_next      = state;
    clr_next        = clr;
    used_count_next = used_count;
    req_now_next    = req_now;
    idx_next        = idx;
    chk_next        = chk;
    pend_next       = pend;
    res_slot_next   = res_slot;
    res_status_next = res_status;
    res_fresh_next  = res_fresh;
    ram_we          = 1'b0;
    ram_waddr       = clr;
    ram_wdata       = '0;
    ram_raddr       = idx[IW-1:0];
    in_ready        = 1'b0;
    load_out        = 1'b0;

    unique case (state)
      sard_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr;
        clr_next  = clr + 1'b1;
        if (clr == LAST_SLOT) begin
          state_next = sard_pkg::S_IDLE;
        end
      end

      sard_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (req.valid) begin
          req_now_next   = req.now_ms;
          res_fresh_next = 1'b0;
          if (req.func == sard_pkg::FUNC_FREE) begin
            res_slot_next = req.slot;
            if ((slot_w >= SW'(used_count)) || (slot_w >= SLOTS_W)) begin
              res_status_next = sard_pkg::ST_BEYOND;
            end else begin
              res_status_next = sard_pkg::ST_OK;
              ram_we          = 1'b1;
              ram_waddr       = IW'(req.slot);
              ram_wdata       = {1'b1, req.now_ms};
            end
            state_next = sard_pkg::S_DONE;
          end else begin
            used_count_next = CW'(raised);
            idx_next        = SW'(reserved_slots);
            pend_next       = 1'b0;
            state_next      = sard_pkg::S_SCAN;
          end
        end
      end

      sard_pkg::S_SCAN: begin
        if (pend && hit) begin
          ram_we          = 1'b1;
          ram_waddr       = chk;
          ram_wdata       = '0;
          res_slot_next   = sard_pkg::SLOT_W'(chk);
          res_status_next = sard_pkg::ST_OK;
          res_fresh_next  = 1'b0;
          state_next      = sard_pkg::S_DONE;
        end else if (!issue) begin
          // Nothing reusable below the count: extend it or report full.
          // Entries at or above the count still hold their cleared flag.
          if (used_count == SLOTS_C) begin
            res_slot_next   = '0;
            res_status_next = sard_pkg::ST_FULL;
            res_fresh_next  = 1'b0;
          end else begin
            res_slot_next   = sard_pkg::SLOT_W'(used_count);
            res_status_next = sard_pkg::ST_OK;
            res_fresh_next  = 1'b1;
            used_count_next = used_count + 1'b1;
          end
          state_next = sard_pkg::S_DONE;
        end else begin
          idx_next  = idx + 1'b1;
          chk_next  = idx[IW-1:0];
          pend_next = 1'b1;
        end
      end

      sard_pkg::S_DONE: begin
        if (!out_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = sard_pkg::S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sard_pkg::S_CLEAR;
      clr        <= '0;
      used_count <= '0;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      clr        <= clr_next;
      used_count <= used_count_next;
      pend       <= pend_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_now    <= req_now_next;
    idx        <= idx_next;
    chk        <= chk_next;
    res_slot   <= res_slot_next;
    res_status <= res_status_next;
    res_fresh  <= res_fresh_next;
    if (load_out) begin
      out_slot   <= res_slot;
      out_status <= res_status;
      out_fresh  <= res_fresh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved_slots <= sard_pkg::RESERVED_RST;
      reuse_delay_ms <= sard_pkg::DELAY_RST;
      warmup_ms      <= sard_pkg::WARMUP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sard_pkg::CFG_RESERVED: reserved_slots <= cfg_data[sard_pkg::RES_W-1:0];
        sard_pkg::CFG_DELAY:    reuse_delay_ms <= cfg_data;
        sard_pkg::CFG_WARMUP:   warmup_ms      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign req.ready    = in_ready;
  assign rsp.valid    = out_valid;
  assign rsp.slot_out = out_slot;
  assign rsp.status   = out_status;
  assign rsp.fresh    = out_fresh;

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    used_count <= SLOTS_C)
    else $error("high-water count exceeds the table size");

  a_count_mono: assert property (@(posedge clk) disable iff (rst)
    state != sard_pkg::S_CLEAR |=> used_count >= $past(used_count))
    else $error("high-water count decreased");

  a_fresh_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.fresh |-> rsp.status == sard_pkg::ST_OK)
    else $error("fresh result carries an error status");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    state == sard_pkg::S_SCAN && pend |-> SW'(chk) < SW'(used_count))
    else $error("scan checked an entry at or above the count");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    state == sard_pkg::S_CLEAR |-> !req.ready && !rsp.valid)
    else $error("channel active during the clearing pass");

endmodule

FILE: hw/rtl/sard_ram.sv
module sard_ram #(
  parameter int WIDTH = sard_pkg::WORD_W,
  parameter int DEPTH = sard_pkg::SLOTS_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sim/slot_allocator_reuse_delay_top_test.sv
`timescale 1ns / 1ps

module slot_allocator_reuse_delay_top_test;

  localparam int SLOTS          = sard_pkg::SLOTS_DEF;
  localparam int STALL_LIMIT    = 6000;
  localparam int RX_HOLD_CYCLES = 300;

  typedef struct packed {
    logic [sard_pkg::SLOT_W-1:0]   slot;
    logic [sard_pkg::STATUS_W-1:0] status;
    logic                          fresh;
  } slot_result_t;

  // Tracks the slot table and configuration and queues the expected result
  // of every accepted request.
  class slot_scoreboard;
    logic [sard_pkg::RES_W-1:0]  reserved;
    logic [sard_pkg::MS_W-1:0]   delay_ms;
    logic [sard_pkg::MS_W-1:0]   warmup;
    bit                          free_flag[SLOTS];
    logic [sard_pkg::TIME_W-1:0] freed_at[SLOTS];
    int unsigned                 high_water;
    slot_result_t                expected_q[$];
    int                          errors;

    function new();
      reserved   = sard_pkg::RESERVED_RST;
      delay_ms   = sard_pkg::DELAY_RST;
      warmup     = sard_pkg::WARMUP_RST;
      high_water = 0;
      errors     = 0;
      foreach (free_flag[i]) free_flag[i] = 1'b0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(logic [sard_pkg::CFG_IDX_W-1:0] idx,
                            logic [sard_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        sard_pkg::CFG_RESERVED: reserved = data[sard_pkg::RES_W-1:0];
        sard_pkg::CFG_DELAY:    delay_ms = data[sard_pkg::MS_W-1:0];
        sard_pkg::CFG_WARMUP:   warmup   = data[sard_pkg::MS_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(logic func, logic [sard_pkg::SLOT_W-1:0] slot,
                               logic [sard_pkg::TIME_W-1:0] now);
      slot_result_t r;
      int unsigned  floor_idx;
      int unsigned  i;
      bit           hit;
      r.slot   = '0;
      r.status = sard_pkg::ST_OK;
      r.fresh  = 1'b0;
      if (func == sard_pkg::FUNC_FREE) begin
        r.slot = slot;
        if (slot >= high_water) begin
          r.status = sard_pkg::ST_BEYOND;
        end else begin
          free_flag[slot] = 1'b1;
          freed_at[slot]  = now;
        end
      end else begin
        floor_idx = (reserved < SLOTS) ? reserved : SLOTS;
        if (high_water < floor_idx) high_water = floor_idx;
        hit = 1'b0;
        i = reserved;
        // A slot freed during warm-up is reusable at once; otherwise its age
        // must exceed the delay, and a free time in the future never does.
        while (i < high_water && !hit) begin
          if (free_flag[i] && (freed_at[i] < warmup ||
              (now >= freed_at[i] && (now - freed_at[i]) > delay_ms)))
            hit = 1'b1;
          else
            i++;
        end
        if (hit) begin
          free_flag[i] = 1'b0;
          r.slot = i[sard_pkg::SLOT_W-1:0];
        end else if (high_water >= SLOTS) begin
          r.status = sard_pkg::ST_FULL;
        end else begin
          i = high_water;
          high_water++;
          free_flag[i] = 1'b0;
          r.slot  = i[sard_pkg::SLOT_W-1:0];
          r.fresh = 1'b1;
        end
      end
      expected_q.push_back(r);
    endfunction

    function void mismatch(string what, int exp_val, int act_val);
      errors++;
      if (errors <= 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, exp_val, act_val);
    endfunction

    function void check_result(logic [sard_pkg::SLOT_W-1:0] slot_out,
                               logic [sard_pkg::STATUS_W-1:0] status, logic fresh);
      slot_result_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result slot %0d status %0d with no request pending",
                   $realtime, slot_out, status);
        return;
      end
      exp_r = expected_q.pop_front();
      if (slot_out !== exp_r.slot)
        mismatch("slot_out", int'(exp_r.slot), int'(slot_out));
      if (status !== exp_r.status)
        mismatch("status", int'(exp_r.status), int'(status));
      if (fresh !== exp_r.fresh)
        mismatch("fresh", int'(exp_r.fresh), int'(fresh));
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [sard_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sard_pkg::CFG_DATA_W-1:0] cfg_data;

  sard_req_if req_ch ();
  sard_rsp_if rsp_ch ();

  slot_allocator_reuse_delay_top #(
    .SLOTS(SLOTS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  slot_scoreboard sb = new();

  int          tx_idle_pct = 13;
  int          rx_idle_pct = 60;
  bit          rx_hold     = 1'b0;
  bit [31:0]   clock_ms    = '0;

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
      if (req_ch.valid && req_ch.ready)
        sb.note_request(req_ch.func, req_ch.slot, req_ch.now_ms);
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_result(rsp_ch.slot_out, rsp_ch.status, rsp_ch.fresh);
    end
  end

  // Ends the run when no transfer happens on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : receiver
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold) begin
        rx_hold = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
      end
      rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer
  // with valid still high, so a following request keeps it up.
  task automatic send_req(input logic func, input logic [sard_pkg::SLOT_W-1:0] slot,
                          input logic [sard_pkg::TIME_W-1:0] now);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.func   <= func;
    req_ch.slot   <= slot;
    req_ch.now_ms <= now;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_config(input int unsigned res, input int unsigned dly,
                            input int unsigned warm);
    cfg_we    <= 1'b1;
    cfg_index <= sard_pkg::CFG_RESERVED;
    cfg_data  <= res[sard_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_index <= sard_pkg::CFG_DELAY;
    cfg_data  <= dly[sard_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_index <= sard_pkg::CFG_WARMUP;
    cfg_data  <= warm[sard_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Half allocates and half frees, of slots mostly in the allocatable range;
  // times creep forward on the scale of the delay; some are stale or wild.
  task automatic run_random(input int count);
    logic                          func;
    logic [sard_pkg::SLOT_W-1:0]   slot;
    logic [sard_pkg::TIME_W-1:0]   now;
    int unsigned                   roll;
    int unsigned                   lo;
    int unsigned                   hi;
    repeat (count) begin
      func = ($urandom_range(0, 99) < 50) ? sard_pkg::FUNC_ALLOC : sard_pkg::FUNC_FREE;
      lo = 32'(sb.reserved);
      hi = sb.high_water;
      roll = $urandom_range(0, 99);
      if (roll < 80 && hi > lo)
        slot = sard_pkg::SLOT_W'($urandom_range(lo, hi - 1));
      else if (roll < 90)
        slot = sard_pkg::SLOT_W'($urandom_range(0, (lo < SLOTS) ? lo : SLOTS - 1));
      else
        slot = sard_pkg::SLOT_W'($urandom_range(0, SLOTS - 1));
      roll = $urandom_range(0, 99);
      if (roll < 90)
        clock_ms += $urandom_range(0, sb.delay_ms / 4 + 64);
      else if (roll < 96)
        clock_ms += $urandom_range(0, 200000);
      now = clock_ms;
      if (roll >= 96 && roll < 99)
        now = clock_ms - $urandom_range(1, 1000);
      else if (roll == 99)
        now = $urandom;
      send_req(func, slot, now);
    end
  endtask

  task automatic run_phase(input int unsigned res, input int unsigned dly,
                           input int unsigned warm, input int tx_pct, input int rx_pct,
                           input int count);
    wait_drained();
    set_config(res, dly, warm);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    run_random(count);
  endtask

  initial begin : stimulus
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = sard_pkg::CFG_RESERVED;
    cfg_data      = '0;
    req_ch.valid  = 1'b0;
    req_ch.func   = sard_pkg::FUNC_ALLOC;
    req_ch.slot   = '0;
    req_ch.now_ms = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Reset configuration: the first allocate lifts the count to the reserve,
    // warm-up reuse, the delay boundary, time running behind a free time,
    // frees of a reserved slot and of a slot beyond the count.
    send_req(sard_pkg::FUNC_ALLOC, 10'd0,    32'd0);
    send_req(sard_pkg::FUNC_ALLOC, 10'd0,    32'd0);
    send_req(sard_pkg::FUNC_ALLOC, 10'd0,    32'd10);
    send_req(sard_pkg::FUNC_FREE,  10'd2,    32'd100);
    send_req(sard_pkg::FUNC_FREE,  10'd0,    32'd100);
    send_req(sard_pkg::FUNC_FREE,  10'd1023, 32'd100);
    send_req(sard_pkg::FUNC_ALLOC, 10'd0,    32'd100);
    send_req(sard_pkg::FUNC_FREE,  10'd3,    32'd3000);
    send_req(sard_pkg::FUNC_ALLOC, 10'd0,    32'd3200);
    send_req(sard_pkg::FUNC_ALLOC, 10'd0,    32'd3500);
    send_req(sard_pkg::FUNC_ALLOC, 10'd0,    32'd3501);
    send_req(sard_pkg::FUNC_FREE,  10'd4,    32'hFFFF_FFFF);
    send_req(sard_pkg::FUNC_ALLOC, 10'd0,    32'd5000);
    send_req(sard_pkg::FUNC_ALLOC, 10'd0,    32'hFFFF_FFFF);
    send_req(sard_pkg::FUNC_FREE,  10'd5,    32'd0);
    send_req(sard_pkg::FUNC_ALLOC, 10'd0,    32'd0);
    send_req(sard_pkg::FUNC_ALLOC, 10'd1023, 32'd6000);
    clock_ms = 32'd10000;
    run_random(80);

    run_phase(1, 0, 0, 13, 60, 100);
    run_phase(16, 65535, 65535, 60, 13, 100);
    run_phase(64, 300, 1000, 60, 13, 40);
    // Hold the receiver off while requests keep coming.
    rx_hold = 1'b1;
    run_random(60);
    run_phase($urandom_range(1, 200), $urandom_range(0, 65535), $urandom_range(0, 65535),
              0, 0, 100);

    // A reserve at the table size fills the count at once: the scan is empty.
    wait_drained();
    set_config(1024, 0, 0);
    send_req(sard_pkg::FUNC_ALLOC, 10'd0,    clock_ms);
    send_req(sard_pkg::FUNC_ALLOC, 10'd0,    clock_ms);
    send_req(sard_pkg::FUNC_FREE,  10'd1023, clock_ms);
    send_req(sard_pkg::FUNC_ALLOC, 10'd0,    clock_ms + 32'd5);
    run_phase(1000, 20, 0, 0, 0, 80);

    wait_drained();
    repeat (SLOTS + 8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
